@@ rtl/fpsa_pkg.sv @@
// Shared types, constants and helper functions for the five-point stencil average.
package fpsa_pkg;

  // Frame geometry and pixel layout.
  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;
  localparam int unsigned Planes    = 4;
  localparam int unsigned PlaneW    = 8;
  localparam int unsigned CoordW    = $clog2(MaxWidth);
  localparam int unsigned DimW      = CoordW + 1;
  localparam int unsigned AddrW     = $clog2(MaxWidth * MaxHeight);
  localparam int unsigned PixelW    = Planes * PlaneW;
  localparam int unsigned SumW      = PlaneW + 3;

  // Divide by five as a multiply by a scaled reciprocal, exact for sums of five bytes.
  localparam int unsigned DivShift  = 13;
  localparam int unsigned DivMul    = (1 << DivShift) / 5 + 1;
  localparam int unsigned ProdW     = SumW + DivShift;

  // Input opcodes.
  localparam logic OpWrite   = 1'b0;
  localparam logic OpCompute = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;
  localparam logic [1:0] RegHorizDist   = 2'd2;
  localparam logic [1:0] RegVertDist    = 2'd3;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [DimW-1:0]   dim_t;
  typedef logic [PlaneW-1:0] plane_t;
  typedef logic [PixelW-1:0] pixel_t;
  typedef logic [AddrW-1:0]  addr_t;

  // Control from the sequencer to the accumulator.
  typedef struct packed {
    logic   rd_vld;
    logic   first;
    logic   divide;
    coord_t col;
    coord_t row;
  } acc_ctrl_t;

  // A frame size of zero acts as one; anything above the maximum saturates.
  function automatic dim_t eff_dim(dim_t v, dim_t max_v);
    dim_t r;
    r = v;
    if (v == '0) r = dim_t'(1);
    else if (v > max_v) r = max_v;
    return r;
  endfunction

  // Clamp a coordinate to the last valid index.
  function automatic coord_t clamp_hi(coord_t v, coord_t last);
    return (v > last) ? last : v;
  endfunction

  // Coordinate plus distance, clamped to the last valid index.
  function automatic coord_t clamp_add(coord_t c, coord_t d, coord_t last);
    dim_t s;
    s = {1'b0, c} + {1'b0, d};
    return (s > {1'b0, last}) ? last : s[CoordW-1:0];
  endfunction

  // Coordinate minus distance, clamped at zero.
  function automatic coord_t clamp_sub(coord_t c, coord_t d);
    dim_t s;
    s = {1'b0, c} - {1'b0, d};
    return s[DimW-1] ? '0 : s[CoordW-1:0];
  endfunction

  // Floor of a five-cell sum divided by five.
  function automatic plane_t div5(logic [SumW-1:0] s);
    logic [ProdW-1:0] prod;
    prod = ProdW'(s) * ProdW'(DivMul);
    return prod[DivShift +: PlaneW];
  endfunction

endpackage

@@ rtl/fpsa_store.sv @@
// Single-port frame store with registered read data.
module fpsa_store (
  input  logic           clk_i,
  input  logic           we_i,
  input  fpsa_pkg::addr_t  addr_i,
  input  fpsa_pkg::pixel_t wdata_i,
  output fpsa_pkg::pixel_t rdata_o
);
  import fpsa_pkg::*;

  pixel_t mem [MaxWidth * MaxHeight];
  pixel_t rdata_q;

  // One access per cycle: a write, or a read whose word appears next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fpsa_seq.sv @@
// Sequencer: configuration registers, coordinate clamping and store address generation.
module fpsa_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 opcode_i,
  input  fpsa_pkg::coord_t     column_i,
  input  fpsa_pkg::coord_t     row_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  fpsa_pkg::dim_t       cfg_data_i,
  output logic                 mem_we_o,
  output fpsa_pkg::addr_t      mem_addr_o,
  output fpsa_pkg::acc_ctrl_t  ctrl_o
);
  import fpsa_pkg::*;

  typedef enum logic [1:0] {SIdle, SRead, SDrain, SDiv} state_e;
  typedef enum logic [2:0] {TapCenter, TapUp, TapRight, TapDown, TapLeft} tap_e;

  state_e state_q;
  tap_e   tap_q;
  logic   busy_q, rd_vld_q, first_q;
  dim_t   fw_q, fh_q;
  coord_t hd_q, vd_q, cx_q, cy_q;

  dim_t   eff_w, eff_h;
  coord_t last_w, last_h, in_cx, in_cy, tap_col, tap_row;
  logic   accept, in_frame;

  // Effective frame size and the last valid column and row.
  always_comb begin
    eff_w  = eff_dim(fw_q, dim_t'(MaxWidth));
    eff_h  = eff_dim(fh_q, dim_t'(MaxHeight));
    last_w = coord_t'(eff_w - dim_t'(1));
    last_h = coord_t'(eff_h - dim_t'(1));
    in_cx  = clamp_hi(column_i, last_w);
    in_cy  = clamp_hi(row_i, last_h);
  end

  assign accept   = start && !busy_q;
  assign in_frame = ({1'b0, column_i} < eff_w) && ({1'b0, row_i} < eff_h);

  // Neighbour coordinate for the tap being read.
  always_comb begin
    tap_col = cx_q;
    tap_row = cy_q;
    unique case (tap_q)
      TapCenter: ;
      TapUp:     tap_row = clamp_sub(cy_q, vd_q);
      TapRight:  tap_col = clamp_add(cx_q, hd_q, last_w);
      TapDown:   tap_row = clamp_add(cy_q, vd_q, last_h);
      TapLeft:   tap_col = clamp_sub(cx_q, hd_q);
      default:   ;
    endcase
  end

  // A write goes straight to the store on the accepting edge.
  assign mem_we_o   = accept && (opcode_i == OpWrite) && in_frame;
  assign mem_addr_o = mem_we_o ? {row_i, column_i} : {tap_row, tap_col};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= dim_t'(MaxWidth);
      fh_q <= dim_t'(MaxHeight);
      hd_q <= '0;
      vd_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFrameWidth:  fw_q <= cfg_data_i;
        RegFrameHeight: fh_q <= cfg_data_i;
        RegHorizDist:   hd_q <= cfg_data_i[CoordW-1:0];
        RegVertDist:    vd_q <= cfg_data_i[CoordW-1:0];
        default:        ;
      endcase
    end
  end

  // State machine: five reads, a drain state for the last word, then a divide step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      tap_q    <= TapCenter;
      busy_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      first_q  <= 1'b0;
      cx_q     <= '0;
      cy_q     <= '0;
    end else begin
      rd_vld_q <= (state_q == SRead);
      first_q  <= (state_q == SRead) && (tap_q == TapCenter);
      unique case (state_q)
        SIdle: begin
          if (accept && (opcode_i == OpCompute)) begin
            state_q <= SRead;
            tap_q   <= TapCenter;
            busy_q  <= 1'b1;
            cx_q    <= in_cx;
            cy_q    <= in_cy;
          end
        end
        SRead: begin
          if (tap_q == TapLeft) begin
            state_q <= SDrain;
          end else begin
            tap_q <= tap_e'(tap_q + 3'd1);
          end
        end
        SDrain: begin
          state_q <= SDiv;
        end
        SDiv: begin
          state_q <= SIdle;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= SIdle;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy = busy_q;

  always_comb begin
    ctrl_o.rd_vld = rd_vld_q;
    ctrl_o.first  = first_q;
    ctrl_o.divide = (state_q == SDiv);
    ctrl_o.col    = cx_q;
    ctrl_o.row    = cy_q;
  end

`ifndef SYNTH
  // The store is written only while no compute is in flight.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == SIdle))
    else $error("store write during a compute");

  // A compute leaves the read phase after the fifth tap.
  a_read_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRead && tap_q == TapLeft) |=> (state_q == SDrain))
    else $error("read phase did not end after the last tap");

  // Busy tracks the state machine.
  a_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q != SIdle))
    else $error("busy out of step with state");

  // An accepted compute makes the block busy on the next cycle.
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == OpCompute) |=> busy_q)
    else $error("accepted compute did not raise busy");
`endif

endmodule

@@ rtl/fpsa_acc.sv @@
// Shared accumulator over the five taps and the divide-by-five output stage.
module fpsa_acc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpsa_pkg::acc_ctrl_t ctrl_i,
  input  fpsa_pkg::pixel_t    rdata_i,
  output logic                valid_o,
  output fpsa_pkg::coord_t    col_o,
  output fpsa_pkg::coord_t    row_o,
  output fpsa_pkg::plane_t    plane_o [fpsa_pkg::Planes]
);
  import fpsa_pkg::*;

  logic [SumW-1:0] sum_q [Planes];
  plane_t          res_q [Planes];
  coord_t          col_q, row_q;
  logic            valid_q;

  // One add per plane each cycle a word comes back; the first word reloads.
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < Planes; p++) begin
      if (ctrl_i.rd_vld) begin
        sum_q[p] <= (ctrl_i.first ? '0 : sum_q[p])
                  + SumW'(rdata_i[p*PlaneW +: PlaneW]);
      end
      if (ctrl_i.divide) begin
        res_q[p] <= div5(sum_q[p]);
      end
    end
    if (ctrl_i.divide) begin
      col_q <= ctrl_i.col;
      row_q <= ctrl_i.row;
    end
  end

  // Result strobe: raised in the cycle after the divide step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.divide;
    end
  end

  assign valid_o = valid_q;
  assign col_o   = col_q;
  assign row_o   = row_q;
  assign plane_o = res_q;

`ifndef SYNTH
  // The divide never overlaps a word still coming back from the store.
  a_div_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.divide |-> !ctrl_i.rd_vld && $past(ctrl_i.rd_vld))
    else $error("divide overlaps accumulation");
`endif

endmodule

@@ rtl/five_point_stencil_average_core.sv @@
// Top level of the five-point stencil average: frame store, sequencer and accumulator.
//
//   Channel   Direction  Handshake                  Word
//   command   in         start high, busy low       opcode, column, row, four planes
//   result    out        result_valid_o, 1 cycle    clamped column, row, four averages
//   config    in         cfg_we_i, no wait          cfg_idx_i selects, cfg_data_i
//
// A write word is written on the accepting edge and busy stays low, so a new word may follow at once.
// A compute word holds busy through five reads of the single-ported frame store,
// a drain state for the last read word and one divide step; the result strobe comes
// together with the fall of busy, in the first cycle a new word can be taken again.
// Reset clears the control and configuration; the frame store keeps no reset value.
// The receiver cannot stall the result.
module five_point_stencil_average_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    opcode_i,
  input  fpsa_pkg::coord_t        column_i,
  input  fpsa_pkg::coord_t        row_i,
  input  fpsa_pkg::plane_t        plane_zero_in_i,
  input  fpsa_pkg::plane_t        plane_one_in_i,
  input  fpsa_pkg::plane_t        plane_two_in_i,
  input  fpsa_pkg::plane_t        plane_three_in_i,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  fpsa_pkg::dim_t          cfg_data_i,
  output logic                    result_valid_o,
  output fpsa_pkg::coord_t        result_column_o,
  output fpsa_pkg::coord_t        result_row_o,
  output fpsa_pkg::plane_t        plane_zero_out_o,
  output fpsa_pkg::plane_t        plane_one_out_o,
  output fpsa_pkg::plane_t        plane_two_out_o,
  output fpsa_pkg::plane_t        plane_three_out_o
);
  import fpsa_pkg::*;

  logic      mem_we;
  addr_t     mem_addr;
  pixel_t    wdata, rdata;
  acc_ctrl_t ctrl;
  plane_t    planes [Planes];

  // Plane zero sits in the low byte of a stored word.
  assign wdata = {plane_three_in_i, plane_two_in_i, plane_one_in_i, plane_zero_in_i};

  fpsa_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .opcode_i   (opcode_i),
    .column_i   (column_i),
    .row_i      (row_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .ctrl_o     (ctrl)
  );

  fpsa_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  fpsa_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .rdata_i (rdata),
    .valid_o (result_valid_o),
    .col_o   (result_column_o),
    .row_o   (result_row_o),
    .plane_o (planes)
  );

  assign plane_zero_out_o  = planes[0];
  assign plane_one_out_o   = planes[1];
  assign plane_two_out_o   = planes[2];
  assign plane_three_out_o = planes[3];

endmodule
